@@ design/ssf_pkg.sv @@
// Shared types and signature constants for the signature scrub filter.
// No dependencies; imported by ssf_scrub and signature_scrub_filter.
package ssf_pkg;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic [15:0] match_total;
    } out_word_t;

    localparam int SIG_COUNT = 16;
    localparam int SIG_MAX   = 38;

    localparam int SIG_LEN [SIG_COUNT] = '{
        19, 16, 21, 38, 11, 10, 12, 9, 11, 10, 8, 8, 11, 7, 13, 9
    };

    // Right-aligned: the last byte of a signature sits in bits [7:0].
    localparam logic [SIG_MAX*8-1:0] SIG_DATA [SIG_COUNT] = '{
        304'h456e69676d612070726f746563746f72207601,
        304'h64656e75766f5f617464000000000000,
        304'h4e5549544b415f4f4e4546494c455f504152454e54,
        304'h566964656f20637265617465642062792053435245454e324558452f53435245454e32535746,
        304'h736b65796472762e646c6c,
        304'h48415350444f53445256,
        304'h4d415258444556312e535953,
        304'h4d784c50545f53656d,
        304'h6e6574686173702e696e69,
        304'h73656e7365342e646c6c,
        304'h534e544e4c555342,
        304'h524e424f7370726f,
        304'h535349564444502e444c4c,
        304'h574942554b4559,
        304'h5c5c2e5c57495a5a4b4559524c,
        304'h5c5c2e5c4e564b4559
    };

    function automatic byte_t sig_byte(input int s, input int i);
        byte_t b;
        b = 8'h00;
        if (i < SIG_LEN[s])
        begin
            b = SIG_DATA[s][(SIG_LEN[s] - 1 - i) * 8 +: 8];
        end
        return b;
    endfunction

endpackage

@@ design/ssf_scrub.sv @@
// Head-of-window signature test and clear for the signature scrub filter.
// Depends on ssf_pkg for the signature table.
module ssf_scrub #(
    parameter int WINDOW_LEN = 38,
    parameter int FILL_W     = 6
) (
    input  ssf_pkg::byte_t   window [WINDOW_LEN],
    input  logic [FILL_W-1:0] fill,
    output ssf_pkg::byte_t   scrubbed [WINDOW_LEN],
    output logic             hit
);
    import ssf_pkg::*;

    logic [SIG_COUNT-1:0] eq;
    logic [SIG_COUNT-1:0] first;
    logic [SIG_MAX-1:0]   clr;

    always_comb
    begin
        for (int s = 0; s < SIG_COUNT; s++)
        begin
            eq[s] = (fill >= FILL_W'(SIG_LEN[s]));
            for (int i = 0; i < SIG_MAX; i++)
            begin
                if (i < SIG_LEN[s] && window[i] != sig_byte(s, i))
                begin
                    eq[s] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < SIG_COUNT; s++)
        begin
            first[s] = eq[s];
            for (int t = 0; t < s; t++)
            begin
                if (eq[t])
                begin
                    first[s] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < SIG_MAX; i++)
        begin
            clr[i] = 1'b0;
            for (int s = 0; s < SIG_COUNT; s++)
            begin
                if (first[s] && i < SIG_LEN[s])
                begin
                    clr[i] = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (i < SIG_MAX && clr[i])
            begin
                scrubbed[i] = 8'h00;
            end
            else
            begin
                scrubbed[i] = window[i];
            end
        end
    end

    assign hit = |eq;

endmodule

@@ design/signature_scrub_filter.sv @@
// Top level of the signature scrub filter: window shift register, flow control, match count.
// Depends on ssf_pkg and ssf_scrub.
//
// Bytes enter a window of WINDOW_LEN entries; once it is full, the head byte is tested
// against sixteen fixed signatures, cleared where one matches, and sent out while the next
// byte enters, so steady flow is one byte per cycle while dst_stall is low, set by the
// combinational compare over the window. A byte leaves from the head of a full window, or
// in a drain, through the output register. A word with in_last starts a drain: the held
// bytes (up to WINDOW_LEN) leave one per cycle while dst_stall is low and src_stall stays
// high; the last carries out_last and the final match_total; the count then restarts at zero.
module signature_scrub_filter #(
    parameter int WINDOW_LEN = 38,
    parameter int COUNT_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  ssf_pkg::in_word_t src_data,
    output logic              dst_valid,
    input  logic              dst_stall,
    output ssf_pkg::out_word_t dst_data
);
    import ssf_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_LEN + 1);

    byte_t               win_reg [WINDOW_LEN];
    byte_t               win_next [WINDOW_LEN];
    byte_t               scr [WINDOW_LEN];
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                drain_reg;
    logic                drain_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic                dst_valid_reg;
    logic                dst_valid_next;
    out_word_t           dst_data_reg;
    out_word_t           dst_data_next;

    logic              hit;
    logic              full;
    logic              can_emit;
    logic              emit;
    logic              emit_last;
    logic              accept;
    logic [FILL_W-1:0] wpos;

    ssf_scrub #(
        .WINDOW_LEN (WINDOW_LEN),
        .FILL_W     (FILL_W)
    ) u_scrub (
        .window   (win_reg),
        .fill     (fill_reg),
        .scrubbed (scr),
        .hit      (hit)
    );

    assign full      = (fill_reg == FILL_W'(WINDOW_LEN));
    assign can_emit  = full || (drain_reg && fill_reg != '0);
    assign emit      = can_emit && (!dst_valid_reg || !dst_stall);
    assign emit_last = drain_reg && (fill_reg == FILL_W'(1));
    assign src_stall = drain_reg || (full && !emit);
    assign accept    = src_valid && !src_stall;
    assign wpos      = emit ? fill_reg - FILL_W'(1) : fill_reg;

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (accept && wpos == FILL_W'(i))
            begin
                win_next[i] = src_data.in_byte;
            end
            else if (emit && i < WINDOW_LEN - 1)
            begin
                win_next[i] = scr[i + 1];
            end
            else
            begin
                win_next[i] = win_reg[i];
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept && !emit)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (emit && !accept)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_comb
    begin
        count_inc = count_reg;
        if (hit && count_reg != '1)
        begin
            count_inc = count_reg + COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        drain_next     = drain_reg;
        dst_valid_next = dst_valid_reg && dst_stall;
        dst_data_next  = dst_data_reg;
        if (accept && src_data.in_last)
        begin
            drain_next = 1'b1;
        end
        if (emit)
        begin
            dst_valid_next            = 1'b1;
            dst_data_next.out_byte    = scr[0];
            dst_data_next.out_last    = emit_last;
            dst_data_next.match_total = 16'(count_inc);
            if (emit_last)
            begin
                count_next = '0;
                drain_next = 1'b0;
            end
            else
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            drain_reg     <= 1'b0;
            count_reg     <= '0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            drain_reg     <= drain_next;
            count_reg     <= count_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        dst_data_reg <= dst_data_next;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

`ifndef ASSERT_OFF
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW_LEN))
        else $error("window fill beyond its depth");

    a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> fill_reg != '0)
        else $error("drain active with an empty window");

    a_full_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (full && dst_valid && dst_stall) |-> src_stall)
        else $error("word taken into a full window while output is blocked");

    a_out_from_window: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(fill_reg) != '0)
        else $error("output word raised with no byte held");
`endif

endmodule
